[rtl/tmph_pkg.sv]
// Shared types and constants of the trimmed-mean pH filter.
// No dependencies; used by trimmed_mean_ph_filter.
`default_nettype none

package tmph_pkg;

  localparam int WINDOW_DEF = 40;

  localparam int SAMPLE_W = 10;
  localparam int SLOPE_W  = 15;
  localparam int OFFSET_W = 14;
  localparam int SUM_W    = 16;
  localparam int PH_W     = 16;

  // Width of trimmed_sum * slope, and of 5 * that product plus the rounding half.
  localparam int PROD_W = SUM_W + SLOPE_W;
  localparam int NUM_W  = PROD_W + 4;
  // Bits left after the divide by 1024.
  localparam int QIN_W  = NUM_W - 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SLOPE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = CFG_IDX_W'(1);

  localparam logic [SLOPE_W-1:0]         SLOPE_RST  = SLOPE_W'(3500);
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST = -OFFSET_W'(90);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_MUL,
    ST_SCALE,
    ST_RECIP,
    ST_RMUL,
    ST_FIX,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

[rtl/tmph_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tmph_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 40
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/trimmed_mean_ph_filter.sv]
// Trimmed moving-average pH filter: ring of WINDOW samples in a RAM, drop min and max, scale.
// Depends on tmph_pkg and tmph_ram.
// One item in flight at a time: a new sample is accepted only in the idle state, after the scan
// of the ring RAM read port and the steps trim, multiply, scale, reciprocal, reciprocal multiply,
// fix and output; the output step holds while the result register is full and stalled.
// Reset (rst_n low, synchronous): ring reads as zero through per-entry valid bits, write
// pointer zero, slope 3500, offset -90, no result pending.
`default_nettype none

module trimmed_mean_ph_filter #(
  parameter int WINDOW = tmph_pkg::WINDOW_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic        [tmph_pkg::SAMPLE_W-1:0]  in_sample,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic             [tmph_pkg::SUM_W-1:0]     out_trimmed_sum,
  output logic signed      [tmph_pkg::PH_W-1:0]      out_ph_milli,
  // configuration
  input  wire logic                                  cfg_we,
  input  wire logic        [tmph_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic        [tmph_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(WINDOW);
  localparam int KDIV  = WINDOW - 2;
  localparam int KW    = $clog2(WINDOW - 1);
  localparam int QW    = tmph_pkg::QIN_W;
  localparam int SW    = tmph_pkg::SUM_W;
  localparam int NW    = tmph_pkg::NUM_W;

  localparam logic [AW:0]   WIN_C    = (AW + 1)'(WINDOW);
  localparam logic [AW-1:0] WP_LAST  = AW'(WINDOW - 1);
  localparam logic [NW-1:0] HALF_D   = NW'(512 * KDIV);
  localparam logic [KW-1:0] K_C      = KW'(KDIV);
  // Reciprocal of the window divisor; the estimate it gives is at most one low.
  localparam longint        RECIP    = (64'sd1 <<< QW) / KDIV;
  localparam logic [QW-2:0] RECIP_C  = (QW - 1)'(RECIP);

  localparam logic signed [QW+1:0] PH_MAX = (QW + 2)'(32767);
  localparam logic signed [QW+1:0] PH_MIN = -(QW + 2)'(32768);

  tmph_pkg::state_t state_r, state_nxt;

  logic                                 in_xfer;
  logic                                 out_xfer;
  logic                                 load_out;

  logic [AW-1:0]                        wp_r;
  logic [WINDOW-1:0]                    vld_r;
  logic [AW:0]                          scan_cnt_r;
  logic                                 dv_r;
  logic                                 rd_vld_r;
  logic [tmph_pkg::SAMPLE_W-1:0]        rdata;
  logic [tmph_pkg::SAMPLE_W-1:0]        smp;

  logic [SW-1:0]                        tot_r;
  logic [tmph_pkg::SAMPLE_W-1:0]        lo_r;
  logic [tmph_pkg::SAMPLE_W-1:0]        hi_r;
  logic [SW-1:0]                        trim_r;
  logic [tmph_pkg::PROD_W-1:0]          prod_r;
  logic [NW-1:0]                        num;
  logic [QW-1:0]                        qin_r;
  logic [2*QW-2:0]                      recip_r;
  logic [QW-1:0]                        q0;
  logic [QW+KW-1:0]                     qk_r;
  logic [QW+KW-1:0]                     rem;
  logic [QW-1:0]                        q_r;
  logic signed [QW+1:0]                 ph_full;
  logic signed [tmph_pkg::PH_W-1:0]     ph_sat;

  logic [tmph_pkg::SLOPE_W-1:0]         slope_r;
  logic signed [tmph_pkg::OFFSET_W-1:0] offset_r;

  logic                                 out_valid_r;
  logic [SW-1:0]                        out_sum_r;
  logic signed [tmph_pkg::PH_W-1:0]     out_ph_r;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // Ring storage: write the new sample on transfer, scan reads one entry per cycle.
  tmph_ram #(
    .WIDTH (tmph_pkg::SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wp_r),
    .wdata (in_sample),
    .raddr (scan_cnt_r[AW-1:0]),
    .rdata (rdata)
  );

  // Entries never written since reset read as zero.
  assign smp = rd_vld_r ? rdata : '0;

  // Scaling arithmetic between stage registers.
  assign num = (NW'(prod_r) << 2) + NW'(prod_r) + HALF_D;
  assign q0  = QW'(recip_r[2*QW-2:QW]);
  assign rem = (QW + KW)'(qin_r) - qk_r;

  always_comb begin
    ph_full = $signed({2'b00, q_r}) + (QW + 2)'(offset_r);
    if (ph_full > PH_MAX) begin
      ph_sat = tmph_pkg::PH_W'(PH_MAX);
    end else if (ph_full < PH_MIN) begin
      ph_sat = tmph_pkg::PH_W'(PH_MIN);
    end else begin
      ph_sat = ph_full[tmph_pkg::PH_W-1:0];
    end
  end

  // Sequencer: one item at a time, output register decouples the result side.
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    load_out  = 1'b0;
    unique case (state_r)
      tmph_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = tmph_pkg::ST_SCAN;
        end
      end
      tmph_pkg::ST_SCAN: begin
        // last read data lands in the cycle the count reaches the window size
        if (scan_cnt_r == WIN_C) begin
          state_nxt = tmph_pkg::ST_TRIM;
        end
      end
      tmph_pkg::ST_TRIM:  state_nxt = tmph_pkg::ST_MUL;
      tmph_pkg::ST_MUL:   state_nxt = tmph_pkg::ST_SCALE;
      tmph_pkg::ST_SCALE: state_nxt = tmph_pkg::ST_RECIP;
      tmph_pkg::ST_RECIP: state_nxt = tmph_pkg::ST_RMUL;
      tmph_pkg::ST_RMUL:  state_nxt = tmph_pkg::ST_FIX;
      tmph_pkg::ST_FIX:   state_nxt = tmph_pkg::ST_OUT;
      tmph_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = tmph_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tmph_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmph_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers: pointer, valid bits, scan count, result flag, calibration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      vld_r       <= '0;
      scan_cnt_r  <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      slope_r     <= tmph_pkg::SLOPE_RST;
      offset_r    <= tmph_pkg::OFFSET_RST;
    end else begin
      dv_r <= (state_r == tmph_pkg::ST_SCAN) && (scan_cnt_r != WIN_C);
      if (in_xfer) begin
        vld_r[wp_r] <= 1'b1;
        wp_r        <= (wp_r == WP_LAST) ? '0 : wp_r + 1'b1;
        scan_cnt_r  <= '0;
      end else if (state_r == tmph_pkg::ST_SCAN && scan_cnt_r != WIN_C) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          tmph_pkg::CFG_SLOPE:  slope_r  <= cfg_wdata;
          tmph_pkg::CFG_OFFSET: offset_r <= cfg_wdata[tmph_pkg::OFFSET_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[scan_cnt_r[AW-1:0]];
    if (in_xfer) begin
      tot_r <= '0;
      lo_r  <= '1;
      hi_r  <= '0;
    end else if (dv_r) begin
      tot_r <= tot_r + SW'(smp);
      if (smp < lo_r) lo_r <= smp;
      if (smp > hi_r) hi_r <= smp;
    end
    if (state_r == tmph_pkg::ST_TRIM) begin
      trim_r <= tot_r - SW'(lo_r) - SW'(hi_r);
    end
    if (state_r == tmph_pkg::ST_MUL) begin
      prod_r <= trim_r * slope_r;
    end
    if (state_r == tmph_pkg::ST_SCALE) begin
      // round half up, then drop the factor 1024 of the divisor
      qin_r <= num[NW-1:10];
    end
    if (state_r == tmph_pkg::ST_RECIP) begin
      recip_r <= qin_r * RECIP_C;
    end
    if (state_r == tmph_pkg::ST_RMUL) begin
      qk_r <= q0 * K_C;
    end
    if (state_r == tmph_pkg::ST_FIX) begin
      // advance the estimate once if the remainder still covers the divisor
      q_r <= (rem >= (QW + KW)'(K_C)) ? q0 + 1'b1 : q0;
    end
    if (load_out) begin
      out_sum_r <= trim_r;
      out_ph_r  <= ph_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trimmed_sum = out_sum_r;
  assign out_ph_milli    = out_ph_r;

endmodule

`default_nettype wire
